// ===== rtl/core/usgi_pkg.sv =====
// Shared types and codes for the uniform grid spatial index.
// Used by usgi_div, usgi_cell and uniform_grid_spatial_index_core.
`default_nettype none
package usgi_pkg;

  localparam int MaxEntitiesDef = 64;
  localparam logic [30:0] CellSizeRst = 31'd12800;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_MOVE   = 3'd2;
  localparam logic [2:0] CMD_RADIUS = 3'd3;
  localparam logic [2:0] CMD_AREA   = 3'd4;

  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_DONE   = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  typedef enum logic [1:0] {OP_HOLD, OP_INS, OP_REM, OP_ROT} cell_op_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        id;
    logic signed [31:0] cx;
    logic signed [31:0] cz;
  } slot_t;

  typedef struct packed {
    cell_op_t           op;
    logic [31:0]        id;
    logic signed [31:0] cx;
    logic signed [31:0] cz;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/usgi_div.sv =====
// Radix-2 restoring divider with floor and ceiling correction.
// Depends on usgi_pkg.
`default_nettype none
module usgi_div
  import usgi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [31:0] dividend,
  input  wire logic        sgn,
  input  wire logic        round_up,
  input  wire logic [30:0] divisor,
  output logic             done,
  output logic [31:0]      quot
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t     state;
  logic [4:0]  cnt;
  logic [31:0] mag;
  logic [31:0] rem;
  logic [30:0] dvs;
  logic        neg;
  logic        up;
  logic [31:0] trial;
  logic        fits;
  logic        nz;

  always_comb begin
    trial = {rem[30:0], mag[31]};
    fits  = trial >= {1'b0, dvs};
    nz    = rem != 32'd0;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (go) begin
            neg   <= sgn & dividend[31];
            up    <= round_up;
            mag   <= (sgn & dividend[31]) ? (~dividend + 32'd1) : dividend;
            rem   <= 32'd0;
            dvs   <= divisor;
            cnt   <= 5'd0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          // one quotient bit a cycle
          rem <= fits ? (trial - {1'b0, dvs}) : trial;
          mag <= {mag[30:0], fits};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= D_FIX;
        end
        D_FIX: begin
          if (neg)     quot <= nz ? ~mag : (~mag + 32'd1);
          else if (up) quot <= mag + {31'd0, nz};
          else         quot <= mag;
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/usgi_cell.sv =====
// One cell of the sorted entity chain; holds one slot.
// Depends on usgi_pkg.
`default_nettype none
module usgi_cell
  import usgi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire slot_t     prev_ent,
  input  wire slot_t     next_ent,
  input  wire logic      prev_p,
  input  wire logic      prev_q,
  output slot_t          ent,
  output logic           p,
  output logic           q,
  output logic           match,
  output logic           same
);

  slot_t ent_next;
  logic  gt;

  always_comb begin
    gt    = (ent.cx > ctl.cx) || ((ent.cx == ctl.cx) && (ent.cz > ctl.cz));
    match = ent.valid && (ent.id == ctl.id);
    same  = match && (ent.cx == ctl.cx) && (ent.cz == ctl.cz);
    p     = !ent.valid || gt;
    q     = prev_q || match;
  end

  always_comb begin
    ent_next = ent;
    unique case (ctl.op)
      OP_HOLD: ent_next = ent;
      OP_INS: begin
        // take the new slot at the boundary, shift right behind it
        if (p && !prev_p) ent_next = '{valid: 1'b1, id: ctl.id, cx: ctl.cx, cz: ctl.cz};
        else if (p)       ent_next = prev_ent;
      end
      OP_REM: if (q) ent_next = next_ent;
      OP_ROT: ent_next = next_ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) ent.valid <= 1'b0;
    else     ent       <= ent_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/uniform_grid_spatial_index_core.sv =====
// Top level of the uniform grid spatial index.
// Depends on usgi_pkg, usgi_div and usgi_cell.
//
// Channel   Handshake              Payload
// config    psel/penable/pready    paddr, pwdata, prdata (grid pitch at 0)
// command   start, busy            cmd, entity_id, pos_x, pos_z, area_max_x/z, radius
// result    result_valid (strobe)  hit_id, status, last
//
// Busy holds off the next item until the last one is answered: insert, remove
// and move run a 32-step division of both coordinates in parallel plus its
// fix-up, a decision state, up to two chain edits.
// Queries run two division rounds, then the chain rotates once fully past its
// head cell, one cell per cycle, then the final item.
// Unknown commands answer in the next cycle and leave busy low.
// Reset (rst, synchronous) empties the chain and restores the grid pitch to 50.0.
// Results are strobed for one cycle; the receiver cannot stall them.
//
// The chain stays sorted by cell x, cell z, then arrival in the cell, so a
// query scan returns hits in output order without any sorting.
`default_nettype none
module uniform_grid_spatial_index_core
  import usgi_pkg::*;
#(
  parameter int MAX_ENTITIES = MaxEntitiesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [31:0] entity_id,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] area_max_x,
  input  wire logic [31:0] area_max_z,
  input  wire logic [30:0] radius,
  output logic             result_valid,
  output logic [31:0]      hit_id,
  output logic [2:0]       status,
  output logic             last
);

  localparam int CntW = $clog2(MAX_ENTITIES + 1);
  localparam int IdxW = $clog2(MAX_ENTITIES);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_DEC, S_REM, S_INS, S_DIV2, S_SCAN, S_FIN
  } state_t;

  state_t             state;
  logic [30:0]        grid_pitch;
  logic [CntW-1:0]    count;
  logic [IdxW-1:0]    scan_idx;
  logic [2:0]         cmd_r;
  logic [31:0]        id_r;
  logic [31:0]        amx_r;
  logic [31:0]        amz_r;
  logic [30:0]        rad_r;
  logic signed [31:0] cx;
  logic signed [31:0] cz;
  logic signed [33:0] lox, hix, loz, hiz;
  logic               follow_ins;
  logic               pend_v;
  logic [31:0]        pend_id;

  logic        accept, cmd_ok, cfg_wr;
  logic [30:0] cs_eff;
  logic        go_x, go_z, done_x, done_z;
  logic [31:0] dvd_x, dvd_z, q_x, q_z;
  logic        sgn_x, up_x;

  cell_ctl_t             ctl;
  slot_t                 ent [MAX_ENTITIES];
  logic [MAX_ENTITIES-1:0] pv, qv, mv, sv, vv;
  slot_t                 tail_next;

  logic               any_match, any_same, head_hit;
  logic signed [33:0] hx, hz;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, grid_pitch} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst)                          grid_pitch <= CellSizeRst;
    else if (cfg_wr && !paddr[2])     grid_pitch <= pwdata[30:0];
  end

  assign cs_eff = (grid_pitch == 31'd0) ? 31'd1 : grid_pitch;
  assign busy   = state != S_IDLE;
  assign accept = start && !busy;
  assign cmd_ok = cmd == CMD_INSERT || cmd == CMD_REMOVE || cmd == CMD_MOVE ||
                  cmd == CMD_RADIUS || cmd == CMD_AREA;

  // dividers: first round takes both positions, second round the radius or
  // the area maximum
  always_comb begin
    go_x  = (accept && cmd_ok) ||
            (state == S_DEC && (cmd_r == CMD_RADIUS || cmd_r == CMD_AREA));
    go_z  = (accept && cmd_ok) || (state == S_DEC && cmd_r == CMD_AREA);
    up_x  = (state != S_IDLE) && (cmd_r == CMD_RADIUS);
    sgn_x = !up_x;
    dvd_x = (state == S_IDLE) ? pos_x :
            (cmd_r == CMD_RADIUS) ? {1'b0, rad_r} : amx_r;
    dvd_z = (state == S_IDLE) ? pos_z : amz_r;
  end

  usgi_div u_div_x (
    .clk(clk), .rst(rst), .go(go_x), .dividend(dvd_x), .sgn(sgn_x),
    .round_up(up_x), .divisor(cs_eff), .done(done_x), .quot(q_x)
  );

  usgi_div u_div_z (
    .clk(clk), .rst(rst), .go(go_z), .dividend(dvd_z), .sgn(1'b1),
    .round_up(1'b0), .divisor(cs_eff), .done(done_z), .quot(q_z)
  );

  // chain control
  always_comb begin
    ctl.id = id_r;
    ctl.cx = cx;
    ctl.cz = cz;
    unique case (state)
      S_REM:   ctl.op = OP_REM;
      S_INS:   ctl.op = OP_INS;
      S_SCAN:  ctl.op = OP_ROT;
      default: ctl.op = OP_HOLD;
    endcase
    tail_next = (state == S_SCAN) ? ent[0] : '0;
  end

  for (genvar i = 0; i < MAX_ENTITIES; i++) begin : g_cell
    slot_t prev_e, next_e;
    logic  prev_p, prev_q;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_p = 1'b0;
      assign prev_q = 1'b0;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_p = pv[i-1];
      assign prev_q = qv[i-1];
    end
    if (i == MAX_ENTITIES - 1) begin : g_tail
      assign next_e = tail_next;
    end else begin : g_mid
      assign next_e = ent[i+1];
    end
    usgi_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .prev_ent(prev_e), .next_ent(next_e),
      .prev_p(prev_p), .prev_q(prev_q), .ent(ent[i]), .p(pv[i]), .q(qv[i]),
      .match(mv[i]), .same(sv[i])
    );
    assign vv[i] = ent[i].valid;
  end

  assign any_match = |mv;
  assign any_same  = |sv;

  // head cell range test during the scan
  assign hx = {{2{ent[0].cx[31]}}, ent[0].cx};
  assign hz = {{2{ent[0].cz[31]}}, ent[0].cz};
  assign head_hit = ent[0].valid && hx >= lox && hx <= hix && hz >= loz && hz <= hiz;

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pend_v       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r <= cmd;
            id_r  <= entity_id;
            amx_r <= area_max_x;
            amz_r <= area_max_z;
            rad_r <= radius;
            if (cmd_ok) begin
              state <= S_DIV1;
            end else begin
              // unknown command: answer done at once
              result_valid <= 1'b1;
              hit_id       <= 32'd0;
              status       <= ST_DONE;
              last         <= 1'b1;
            end
          end
        end
        S_DIV1: begin
          if (done_x) begin
            cx    <= q_x;
            cz    <= q_z;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          hit_id <= 32'd0;
          last   <= 1'b1;
          follow_ins <= 1'b0;
          if (cmd_r == CMD_RADIUS || cmd_r == CMD_AREA) begin
            state <= S_DIV2;
          end else if (cmd_r == CMD_REMOVE) begin
            if (any_match) begin
              state <= S_REM;
            end else begin
              result_valid <= 1'b1;
              status       <= ST_ABSENT;
              state        <= S_IDLE;
            end
          end else if (any_match) begin
            if (any_same) begin
              // same cell: keep the order
              result_valid <= 1'b1;
              status       <= ST_DONE;
              state        <= S_IDLE;
            end else begin
              follow_ins <= 1'b1;
              state      <= S_REM;
            end
          end else if (cmd_r == CMD_MOVE) begin
            result_valid <= 1'b1;
            status       <= ST_ABSENT;
            state        <= S_IDLE;
          end else if (count == CntW'(MAX_ENTITIES)) begin
            result_valid <= 1'b1;
            status       <= ST_FULL;
            state        <= S_IDLE;
          end else begin
            state <= S_INS;
          end
        end
        S_REM: begin
          count <= count - CntW'(1);
          if (follow_ins) begin
            state <= S_INS;
          end else begin
            result_valid <= 1'b1;
            status       <= ST_DONE;
            state        <= S_IDLE;
          end
        end
        S_INS: begin
          count        <= count + CntW'(1);
          result_valid <= 1'b1;
          status       <= ST_DONE;
          state        <= S_IDLE;
        end
        S_DIV2: begin
          if (done_x) begin
            if (cmd_r == CMD_RADIUS) begin
              lox <= {{2{cx[31]}}, cx} - {2'b00, q_x};
              hix <= {{2{cx[31]}}, cx} + {2'b00, q_x};
              loz <= {{2{cz[31]}}, cz} - {2'b00, q_x};
              hiz <= {{2{cz[31]}}, cz} + {2'b00, q_x};
            end else begin
              lox <= {{2{cx[31]}}, cx};
              loz <= {{2{cz[31]}}, cz};
              hix <= {{2{q_x[31]}}, q_x};
              hiz <= {{2{q_z[31]}}, q_z};
            end
            scan_idx <= '0;
            pend_v   <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // hold one hit back so the final one can carry last
          if (head_hit) begin
            if (pend_v) begin
              result_valid <= 1'b1;
              hit_id       <= pend_id;
              status       <= ST_HIT;
              last         <= 1'b0;
            end
            pend_id <= ent[0].id;
            pend_v  <= 1'b1;
          end
          if (scan_idx == IdxW'(MAX_ENTITIES - 1)) state <= S_FIN;
          else scan_idx <= scan_idx + IdxW'(1);
        end
        S_FIN: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          hit_id       <= pend_v ? pend_id : 32'd0;
          status       <= pend_v ? ST_HIT : ST_EMPTY;
          pend_v       <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(vv) == int'(count))
    else $error("entry count differs from valid cells");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_ENTITIES)
    else $error("entry count above capacity");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_HIT |-> last)
    else $error("non-hit result not final");

  a_accept_reacts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || result_valid)
    else $error("accepted item neither started nor answered");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for uniform_grid_spatial_index_core: drives commands and pitch writes,
// checks every result strobe against a scoreboard that models the grid index.
// Depends on usgi_pkg and the core RTL.

module testbench
  import usgi_pkg::*;
();

  localparam logic [2:0] ADDR_PITCH = 3'd0;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 200;
  localparam int POOL_SIZE = 72;
  localparam int RAND_PER_PHASE = 72;

  typedef struct {
    logic [2:0]         op;
    logic [31:0]        id;
    logic signed [31:0] px;
    logic signed [31:0] pz;
    logic signed [31:0] mx;
    logic signed [31:0] mz;
    logic [30:0]        rad;
  } grid_cmd_t;

  typedef struct {
    logic [31:0] id;
    logic [2:0]  st;
    logic        lst;
  } grid_res_t;

  // Scoreboard: mirrors the index contents and queues the results that each
  // accepted command must produce.
  class grid_scoreboard;
    bit          occupied[64];
    logic [31:0] ent[64];
    longint      cx[64];
    longint      cz[64];
    int          rank[64];
    int          count;
    longint      csize;
    grid_res_t   awaited[$];
    int          errors;

    function new();
      for (int i = 0; i < 64; i++) occupied[i] = 1'b0;
      count = 0;
      csize = CellSizeRst;
      errors = 0;
    endfunction

    function void set_pitch(logic [30:0] v);
      csize = (v == 31'd0) ? 64'sd1 : longint'(v);
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q -= 1;
      return q;
    endfunction

    function int find_id(logic [31:0] id);
      for (int i = 0; i < 64; i++)
        if (occupied[i] && ent[i] == id) return i;
      return -1;
    endfunction

    function void close_rank(int s);
      for (int i = 0; i < 64; i++)
        if (i != s && occupied[i] && rank[i] > rank[s]) rank[i]--;
    endfunction

    function bit ahead(int a, int b);
      if (cx[a] != cx[b]) return cx[a] < cx[b];
      if (cz[a] != cz[b]) return cz[a] < cz[b];
      return rank[a] < rank[b];
    endfunction

    function void push(logic [31:0] id, logic [2:0] st, logic lst);
      grid_res_t r;
      r.id = id; r.st = st; r.lst = lst;
      awaited = {awaited, r};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Note an accepted command: update the mirror and queue its results.
    function void note(grid_cmd_t c);
      longint x, z, lox, hix, loz, hiz, cr;
      int s, j, n;
      int hits[64];
      x = fdiv(longint'(c.px), csize);
      z = fdiv(longint'(c.pz), csize);
      if (c.op == CMD_INSERT || c.op == CMD_MOVE) begin
        s = find_id(c.id);
        if (s >= 0) begin
          // reinsert acts as a move; same cell keeps its place
          if (cx[s] != x || cz[s] != z) begin
            close_rank(s);
            rank[s] = count - 1;
            cx[s] = x; cz[s] = z;
          end
          push(32'd0, ST_DONE, 1'b1);
        end else if (c.op == CMD_MOVE) begin
          push(32'd0, ST_ABSENT, 1'b1);
        end else begin
          s = 0;
          while (s < 64 && occupied[s]) s++;
          if (s >= 64) begin
            push(32'd0, ST_FULL, 1'b1);
          end else begin
            occupied[s] = 1'b1; ent[s] = c.id; cx[s] = x; cz[s] = z;
            rank[s] = count; count++;
            push(32'd0, ST_DONE, 1'b1);
          end
        end
        return;
      end
      if (c.op == CMD_REMOVE) begin
        s = find_id(c.id);
        if (s < 0) begin
          push(32'd0, ST_ABSENT, 1'b1);
        end else begin
          close_rank(s);
          occupied[s] = 1'b0;
          count--;
          push(32'd0, ST_DONE, 1'b1);
        end
        return;
      end
      if (c.op == CMD_RADIUS) begin
        cr = (longint'(c.rad) + csize - 1) / csize;
        lox = x - cr; hix = x + cr; loz = z - cr; hiz = z + cr;
      end else if (c.op == CMD_AREA) begin
        lox = x; loz = z;
        hix = fdiv(longint'(c.mx), csize);
        hiz = fdiv(longint'(c.mz), csize);
      end else begin
        push(32'd0, ST_DONE, 1'b1);
        return;
      end
      n = 0;
      for (int i = 0; i < 64; i++) begin
        if (!occupied[i]) continue;
        if (cx[i] < lox || cx[i] > hix || cz[i] < loz || cz[i] > hiz) continue;
        j = n;
        while (j > 0 && ahead(i, hits[j-1])) begin
          hits[j] = hits[j-1];
          j--;
        end
        hits[j] = i;
        n++;
      end
      if (n == 0) push(32'd0, ST_EMPTY, 1'b1);
      for (int k = 0; k < n; k++) push(ent[hits[k]], ST_HIT, k == n - 1);
    endfunction

    task check(grid_res_t r);
      grid_res_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result id=%h status=%0d last=%0b", r.id, r.st, r.lst));
        return;
      end
      e = awaited.pop_front();
      if (r.id !== e.id) report($sformatf("hit_id %h, want %h", r.id, e.id));
      if (r.st !== e.st) report($sformatf("status %0d, want %0d", r.st, e.st));
      if (r.lst !== e.lst) report($sformatf("last %0b, want %0b", r.lst, e.lst));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 0;
  logic        busy;
  logic [2:0]  cmd = '0;
  logic [31:0] entity_id = '0, pos_x = '0, pos_z = '0, area_max_x = '0, area_max_z = '0;
  logic [30:0] radius = '0;
  logic        result_valid;
  logic [31:0] hit_id;
  logic [2:0]  status;
  logic        last;

  grid_scoreboard sb = new();
  logic [31:0] id_pool[POOL_SIZE];
  int cycles = 0;
  bit calm = 0;

  uniform_grid_spatial_index_core u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .cmd(cmd), .entity_id(entity_id),
    .pos_x(pos_x), .pos_z(pos_z), .area_max_x(area_max_x), .area_max_z(area_max_z),
    .radius(radius), .result_valid(result_valid), .hit_id(hit_id),
    .status(status), .last(last)
  );

  always #1 clk = ~clk;

  // Count cycles and abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Results cannot be stalled: check every strobe.
  always @(posedge clk) begin
    grid_res_t r;
    if (!rst && result_valid) begin
      r.id = hit_id; r.st = status; r.lst = last;
      sb.check(r);
    end
  end

  // Present an item and hold it until the block takes it; start stays high
  // so a following item can go out back to back.
  task automatic send(grid_cmd_t c);
    cmd <= c.op; entity_id <= c.id; pos_x <= c.px; pos_z <= c.pz;
    area_max_x <= c.mx; area_max_z <= c.mz; radius <= c.rad;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note(c);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start and wait until every expected result has come, then let the
  // block settle so no command is still in flight.
  task automatic drain();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_pitch(logic [30:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_PITCH; pwdata <= {1'b0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_pitch(v);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Positions mostly fall within a few cells of the origin so that queries
  // hit; the rest are full-range or corner values.
  function automatic logic signed [31:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: case ($urandom_range(0, 3))
           0: return 32'sh80000000;
           1: return 32'sh7fffffff;
           2: return 32'sh0;
           default: return -32'sd1;
         endcase
      default: return clamp32((longint'($urandom_range(0, 12)) - 6) * sb.csize
                              + longint'($urandom_range(0, 31'(sb.csize - 1))));
    endcase
  endfunction

  function automatic grid_cmd_t pick_cmd();
    grid_cmd_t c;
    int sel;
    longint r;
    sel = $urandom_range(0, 99);
    if (sel < 36) c.op = CMD_INSERT;
    else if (sel < 48) c.op = CMD_REMOVE;
    else if (sel < 65) c.op = CMD_MOVE;
    else if (sel < 80) c.op = CMD_RADIUS;
    else if (sel < 95) c.op = CMD_AREA;
    else c.op = 3'($urandom_range(5, 7));
    c.id = ($urandom_range(0, 9) < 9) ? id_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
    c.px = pick_pos();
    c.pz = pick_pos();
    c.mx = ($urandom_range(0, 7) == 0) ? pick_pos()
         : clamp32(longint'(c.px) + (longint'($urandom_range(0, 5)) - 1) * sb.csize);
    c.mz = ($urandom_range(0, 7) == 0) ? pick_pos()
         : clamp32(longint'(c.pz) + (longint'($urandom_range(0, 5)) - 1) * sb.csize);
    r = longint'($urandom_range(0, 3)) * sb.csize - longint'($urandom_range(0, 1));
    if (r < 0) r = 0;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    c.rad = ($urandom_range(0, 9) == 0) ? 31'($urandom) : r[30:0];
    return c;
  endfunction

  function automatic grid_cmd_t mk(logic [2:0] op, logic [31:0] id, logic signed [31:0] px,
                                   logic signed [31:0] pz, logic signed [31:0] mx,
                                   logic signed [31:0] mz, int rad);
    grid_cmd_t c;
    c.op = op; c.id = id; c.px = px; c.pz = pz; c.mx = mx; c.mz = mz; c.rad = 31'(rad);
    return c;
  endfunction

  task automatic random_phase(logic [30:0] size, int n, bit tail);
    write_pitch(size);
    for (int i = 0; i < n; i++) begin
      if (tail && i >= n - 60) calm = 1;
      send(pick_cmd());
      if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 3));
      // in the pitch-256 phase, hold off once mid-phase until the block has answered everything
      if (i == n / 2 && size == 31'd256) drain();
    end
    drain();
  endtask

  initial begin
    grid_cmd_t d[$];
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hffffffff;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: edge ids and positions, every command, each special case.
    d = {d, mk(CMD_RADIUS, 0, 0, 0, 0, 0, 0)};                            // empty query
    d = {d, mk(CMD_INSERT, 32'h0, 0, 0, 0, 0, 0)};
    d = {d, mk(CMD_INSERT, 32'hffffffff, -1, -1, 0, 0, 0)};
    d = {d, mk(CMD_INSERT, 32'h12345678, 32'sh7fffffff, 32'sh80000000, 0, 0, 0)};
    d = {d, mk(CMD_INSERT, 32'h5a5a5a5a, 100, 200, 0, 0, 0)};              // same cell as id 0
    d = {d, mk(CMD_INSERT, 32'h0, 12800, 0, 0, 0, 0)};                    // reinsert moves
    d = {d, mk(CMD_MOVE, 32'h5a5a5a5a, 300, 400, 0, 0, 0)};                // same cell
    d = {d, mk(CMD_MOVE, 32'ha5a5a5a5, 0, 0, 0, 0, 0)};                    // absent
    d = {d, mk(CMD_REMOVE, 32'ha5a5a5a5, 0, 0, 0, 0, 0)};                  // absent
    d = {d, mk(CMD_RADIUS, 0, 0, 0, 0, 0, 0)};
    d = {d, mk(CMD_RADIUS, 0, 0, 0, 0, 0, 31'h7fffffff)};
    d = {d, mk(CMD_AREA, 0, 32'sh80000000, 32'sh80000000,
               32'sh7fffffff, 32'sh7fffffff, 0)};
    d = {d, mk(CMD_AREA, 0, 12800, 0, 0, 12800, 0)};                       // reversed x
    d = {d, mk(CMD_AREA, 0, 0, 0, 12799, 12799, 0)};
    d = {d, mk(3'd5, 0, 0, 0, 0, 0, 0)};
    d = {d, mk(3'd6, 32'hffffffff, -1, -1, -1, -1, 31'h7fffffff)};
    d = {d, mk(3'd7, 0, 0, 0, 0, 0, 0)};
    d = {d, mk(CMD_MOVE, 32'h0, 0, 0, 0, 0, 0)};                          // back to end of cell
    d = {d, mk(CMD_RADIUS, 0, 1, 1, 0, 0, 1)};
    d = {d, mk(CMD_REMOVE, 32'h0, 0, 0, 0, 0, 0)};
    d = {d, mk(CMD_AREA, 0, -1, -1, 0, 0, 0)};
    foreach (d[i]) begin
      send(d[i]);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 3));
    end
    drain();

    random_phase(31'd1, RAND_PER_PHASE, 0);
    random_phase(31'h7fffffff, RAND_PER_PHASE, 0);
    random_phase(31'd256, RAND_PER_PHASE, 0);
    random_phase(31'($urandom_range(1, 100000)), RAND_PER_PHASE, 0);
    random_phase(CellSizeRst, RAND_PER_PHASE, 1);

    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
